### rtl/core/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg
// Shared constants, lane type and fixed-point helpers for the sine/cosine
// minimax pipeline.
// ----------------------------------------------------------------------------
package smm_pkg;

   localparam int ANGLE_FRAC_BITS  = 24;
   localparam int RESULT_FRAC_BITS = 30;

   localparam int ANGLE_W  = 32;
   localparam int RESULT_W = 32;
   localparam int ACC_W    = 36;
   localparam int Q_W      = 32 - ANGLE_FRAC_BITS;
   localparam int RED_W    = 70 - ANGLE_FRAC_BITS;
   localparam int CELLS    = 5;

   localparam longint INV2PI_Q32  = 64'd683565276;
   localparam longint PI_Q32      = 64'd13493037705;
   localparam longint TWO_PI_Q32  = 64'd26986075410;
   localparam longint HALF_PI_Q32 = 64'd6746518852;
   localparam longint ONE_Q30     = 64'd1073741824;

   localparam logic signed [ACC_W-1:0] SIN_INIT = -ACC_W'(26);
   localparam logic signed [ACC_W-1:0] COS_INIT = -ACC_W'(280);

   localparam logic signed [ACC_W-1:0] SIN_ADD [CELLS] = '{
      ACC_W'(2956), -ACC_W'(213040), ACC_W'(8947846), -ACC_W'(178956974),
      ACC_W'(ONE_Q30)
   };
   localparam logic signed [ACC_W-1:0] COS_ADD [CELLS] = '{
      ACC_W'(26586), -ACC_W'(1491253), ACC_W'(44739212), -ACC_W'(536870912),
      ACC_W'(ONE_Q30)
   };

   typedef struct packed {
      logic [31:0]              y2;
      logic [31:0]              m30;
      logic                     sin_neg;
      logic                     cos_neg;
      logic signed [ACC_W-1:0]  sin_acc;
      logic signed [ACC_W-1:0]  cos_acc;
   } lane_type;

   // Q2.30 product of a signed value and an unsigned value, rounded half
   // away from zero on the magnitude
   function automatic logic signed [ACC_W-1:0] mul_q30(
      input logic signed [ACC_W-1:0] a,
      input logic        [31:0]      b
   );
      logic [ACC_W-1:0]    ua;
      logic [ACC_W+31:0]   p;
      logic [ACC_W+31:0]   r;
      ua = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
      p  = (ACC_W+32)'(ua) * (ACC_W+32)'(b);
      r  = (p + ((ACC_W+32)'(1) << 29)) >> 30;
      return a[ACC_W-1] ? -$signed(r[ACC_W-1:0]) : $signed(r[ACC_W-1:0]);
   endfunction

endpackage

### rtl/core/smm_front.sv
// ----------------------------------------------------------------------------
// smm_front
// Range reduction, fold to [-pi/2,pi/2] and squaring: four pipeline stages.
// ----------------------------------------------------------------------------
module smm_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic signed [smm_pkg::ANGLE_W-1:0]    in_angle,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output smm_pkg::lane_type                     out_lane
);
   import smm_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic rdy1, rdy2, rdy3, rdy4;

   logic [61:0]                 prod_ff, prod_in;
   logic                        neg1_ff;
   logic signed [ANGLE_W-1:0]   a1_ff;
   logic signed [RED_W-1:0]     y_ff, y_in;
   logic [31:0]                 m30_ff, m30_in;
   logic                        yneg_ff, yneg_in, flip_ff, flip_in;
   logic [31:0]                 y2_ff, y2_in;
   logic [31:0]                 m30_4_ff;
   logic                        yneg4_ff, flip4_ff;

   logic [ANGLE_W-1:0]          amag;
   logic [63:0]                 q_sum;
   logic [Q_W-1:0]              q;
   logic signed [Q_W:0]         qs;
   logic signed [RED_W-1:0]     yf;
   logic [RED_W-1:0]            ym;
   logic [63:0]                 sq;

   assign rdy4     = !v4_ff || out_ready;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   assign v1_in = rdy1 ? in_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;
   assign v4_in = rdy4 ? v3_ff : v4_ff;

   always_comb begin
      amag    = in_angle[ANGLE_W-1] ? ANGLE_W'(-in_angle) : ANGLE_W'(in_angle);
      prod_in = 62'(amag) * 62'(INV2PI_Q32);

      q_sum = 64'(prod_ff) + (64'(1) << (ANGLE_FRAC_BITS + 31));
      q     = q_sum[ANGLE_FRAC_BITS+32 +: Q_W];
      qs    = neg1_ff ? -$signed({1'b0, q}) : $signed({1'b0, q});
      y_in  = (RED_W'(a1_ff) <<< (32 - ANGLE_FRAC_BITS))
            - RED_W'(qs) * RED_W'(TWO_PI_Q32);

      flip_in = 1'b0;
      yf      = y_ff;
      if (y_ff > RED_W'(HALF_PI_Q32)) begin
         yf      = RED_W'(PI_Q32) - y_ff;
         flip_in = 1'b1;
      end else if (y_ff < -RED_W'(HALF_PI_Q32)) begin
         yf      = -RED_W'(PI_Q32) - y_ff;
         flip_in = 1'b1;
      end
      yneg_in = yf[RED_W-1];
      ym      = yneg_in ? RED_W'(-yf) : RED_W'(yf);
      m30_in  = 32'((ym + RED_W'(2)) >> 2);

      sq    = 64'(m30_ff) * 64'(m30_ff);
      y2_in = 32'((sq + (64'(1) << 29)) >> 30);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         prod_ff <= prod_in;
         neg1_ff <= in_angle[ANGLE_W-1];
         a1_ff   <= in_angle;
      end
      if (rdy2) begin
         y_ff <= y_in;
      end
      if (rdy3) begin
         m30_ff  <= m30_in;
         yneg_ff <= yneg_in;
         flip_ff <= flip_in;
      end
      if (rdy4) begin
         y2_ff    <= y2_in;
         m30_4_ff <= m30_ff;
         yneg4_ff <= yneg_ff;
         flip4_ff <= flip_ff;
      end
   end

   assign out_valid        = v4_ff;
   assign out_lane.y2      = y2_ff;
   assign out_lane.m30     = m30_4_ff;
   assign out_lane.sin_neg = yneg4_ff;
   assign out_lane.cos_neg = flip4_ff;
   assign out_lane.sin_acc = SIN_INIT;
   assign out_lane.cos_acc = COS_INIT;

endmodule

### rtl/core/smm_cell.sv
// ----------------------------------------------------------------------------
// smm_cell
// One Horner step for both polynomials: acc = acc * y2 + coefficient.
// ----------------------------------------------------------------------------
module smm_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  smm_pkg::lane_type                   in_lane,
   input  logic signed [smm_pkg::ACC_W-1:0]    sin_add,
   input  logic signed [smm_pkg::ACC_W-1:0]    cos_add,
   output logic                                out_valid,
   input  logic                                out_ready,
   output smm_pkg::lane_type                   out_lane
);
   import smm_pkg::*;

   logic     v_ff, v_in;
   lane_type lane_ff, lane_in;

   assign in_ready = !v_ff || out_ready;
   assign v_in     = in_ready ? in_valid : v_ff;

   always_comb begin
      lane_in         = in_lane;
      lane_in.sin_acc = mul_q30(in_lane.sin_acc, in_lane.y2) + sin_add;
      lane_in.cos_acc = mul_q30(in_lane.cos_acc, in_lane.y2) + cos_add;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         lane_ff <= lane_in;
      end
   end

   assign out_valid = v_ff;
   assign out_lane  = lane_ff;

endmodule

### rtl/core/smm_finish.sv
// ----------------------------------------------------------------------------
// smm_finish
// Final sine multiply and sign fix, then rounding and clamp into the output
// register.
// ----------------------------------------------------------------------------
module smm_finish (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  smm_pkg::lane_type                      in_lane,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic signed [smm_pkg::RESULT_W-1:0]    out_sine,
   output logic signed [smm_pkg::RESULT_W-1:0]    out_cosine
);
   import smm_pkg::*;

   localparam int SH = 30 - RESULT_FRAC_BITS;
   localparam logic [ACC_W-1:0] RND = (ACC_W'(1) << SH) >> 1;
   localparam logic [ACC_W-1:0] LIM = ACC_W'(1) << RESULT_FRAC_BITS;

   logic v1_ff, v1_in, v2_ff, v2_in;
   logic rdy1, rdy2;

   logic signed [ACC_W-1:0]    s_ff, s_in, c_ff, c_in;
   logic signed [ACC_W-1:0]    sp;
   logic signed [RESULT_W-1:0] so_ff, so_in, co_ff, co_in;

   function automatic logic signed [RESULT_W-1:0] to_out(
      input logic signed [ACC_W-1:0] v
   );
      logic [ACC_W-1:0] mag;
      logic [ACC_W-1:0] r;
      mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
      r   = (mag + RND) >> SH;
      if (r > LIM) begin
         r = LIM;
      end
      return v[ACC_W-1] ? -$signed(r[RESULT_W-1:0]) : $signed(r[RESULT_W-1:0]);
   endfunction

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;
   assign v1_in    = rdy1 ? in_valid : v1_ff;
   assign v2_in    = rdy2 ? v1_ff : v2_ff;

   always_comb begin
      sp    = mul_q30(in_lane.sin_acc, in_lane.m30);
      s_in  = in_lane.sin_neg ? -sp : sp;
      c_in  = in_lane.cos_neg ? -in_lane.cos_acc : in_lane.cos_acc;
      so_in = to_out(s_ff);
      co_in = to_out(c_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s_ff <= s_in;
         c_ff <= c_in;
      end
      if (rdy2) begin
         so_ff <= so_in;
         co_ff <= co_in;
      end
   end

   assign out_valid  = v2_ff;
   assign out_sine   = so_ff;
   assign out_cosine = co_ff;

endmodule

### rtl/core/sine_cosine_minimax_top.sv
// ----------------------------------------------------------------------------
// sine_cosine_minimax_top
// Sine and cosine of a Q8.24 angle as Q2.30, minimax polynomials evaluated
// by a row of Horner cells.
// ----------------------------------------------------------------------------
// Pipeline: 4 reduction stages, 5 Horner cells, 2 finish stages.
// Throughput: one angle per cycle while the result stream is not stalled; each
// stage holds one item and advances whenever its successor has room.
// Reset: synchronous, clears all stage valid bits; no other state.
// ----------------------------------------------------------------------------
module sine_cosine_minimax_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] angle
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata     // [31:0] sine_value, [63:32] cosine_value
);
   import smm_pkg::*;

   lane_type lane  [CELLS+1];
   logic     lvalid[CELLS+1];
   logic     lready[CELLS+1];

   logic signed [RESULT_W-1:0] sine, cosine;

   smm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_angle  ($signed(req_tdata)),
      .out_valid (lvalid[0]),
      .out_ready (lready[0]),
      .out_lane  (lane[0])
   );

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      smm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (lvalid[i]),
         .in_ready  (lready[i]),
         .in_lane   (lane[i]),
         .sin_add   (SIN_ADD[i]),
         .cos_add   (COS_ADD[i]),
         .out_valid (lvalid[i+1]),
         .out_ready (lready[i+1]),
         .out_lane  (lane[i+1])
      );
   end

   smm_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (lvalid[CELLS]),
      .in_ready   (lready[CELLS]),
      .in_lane    (lane[CELLS]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_sine   (sine),
      .out_cosine (cosine)
   );

   assign rsp_tdata = {cosine, sine};

endmodule

### test/sine_cosine_checker.sv
// ----------------------------------------------------------------------------
// sine_cosine_checker
// Watches the angle and result streams of sine_cosine_minimax_top. Each angle
// transfer gets its sine/cosine pair worked out in fixed point: the angle is
// reduced by the nearest multiple of 2*pi, folded into [-pi/2,pi/2], and run
// through the minimax Horner polynomials. Each result transfer is compared
// with the oldest pair still owed.
// ----------------------------------------------------------------------------
module sine_cosine_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] angle
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,    // [31:0] sine_value, [63:32] cosine_value
   output int          mismatch_count,
   output int          pending_count,
   output int          compared_count
);

   localparam int ANGLE_FRAC = smm_pkg::ANGLE_FRAC_BITS;
   localparam int OUT_FRAC   = smm_pkg::RESULT_FRAC_BITS;
   localparam int OUT_SHIFT  = 30 - OUT_FRAC;

   localparam longint unsigned INV_TWO_PI_FX = 64'd683565276;
   localparam longint PI_FX      = 64'd13493037705;
   localparam longint TWO_PI_FX  = 64'd26986075410;
   localparam longint HALF_PI_FX = 64'd6746518852;
   localparam longint ONE_FX     = 64'd1073741824;

   localparam longint SINE_COEF [5]   = '{-26, 2956, -213040, 8947846, -178956974};
   localparam longint COSINE_COEF [5] = '{-280, 26586, -1491253, 44739212, -536870912};

   typedef struct packed {
      logic [31:0] angle;
      logic [31:0] sine;
      logic [31:0] cosine;
   } angle_result;

   angle_result pending_sincos [$];

   function automatic longint mul_round_q30(input longint a, input longint b);
      longint unsigned ua;
      longint unsigned ub;
      longint unsigned r;
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      r  = (ua * ub + 64'd536870912) >> 30;
      return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint horner_q30(input bit cosine_poly, input longint y2);
      longint acc;
      acc = cosine_poly ? COSINE_COEF[0] : SINE_COEF[0];
      for (int i = 1; i < 5; i++) begin
         acc = mul_round_q30(acc, y2) + (cosine_poly ? COSINE_COEF[i] : SINE_COEF[i]);
      end
      return mul_round_q30(acc, y2) + ONE_FX;
   endfunction

   function automatic logic [31:0] to_result(input longint v);
      longint unsigned mag;
      mag = (v < 0) ? -v : v;
      if (OUT_SHIFT > 0) begin
         mag = (mag + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
      end
      if (mag > (64'd1 << OUT_FRAC)) begin
         mag = 64'd1 << OUT_FRAC;
      end
      return (v < 0) ? 32'(-mag) : 32'(mag);
   endfunction

   function automatic angle_result sine_cosine_of(input logic [31:0] angle);
      longint          a;
      longint          y;
      longint          turns;
      longint          m30;
      longint          y2;
      longint          s;
      longint          c;
      longint unsigned amag;
      longint unsigned q;
      longint unsigned m;
      bit              flip;
      angle_result     res;
      a     = longint'($signed(angle));
      amag  = (a < 0) ? -a : a;
      q     = (amag * INV_TWO_PI_FX + (64'd1 << (ANGLE_FRAC + 31))) >> (ANGLE_FRAC + 32);
      turns = (a < 0) ? -longint'(q) : longint'(q);
      y     = (a <<< (32 - ANGLE_FRAC)) - turns * TWO_PI_FX;
      flip  = 1'b0;
      if (y > HALF_PI_FX) begin
         y    = PI_FX - y;
         flip = 1'b1;
      end else if (y < -HALF_PI_FX) begin
         y    = -PI_FX - y;
         flip = 1'b1;
      end
      m   = (y < 0) ? -y : y;
      m30 = longint'((m + 64'd2) >> 2);
      y2  = mul_round_q30(m30, m30);
      s   = mul_round_q30(horner_q30(1'b0, y2), m30);
      if (y < 0) begin
         s = -s;
      end
      c = horner_q30(1'b1, y2);
      if (flip) begin
         c = -c;
      end
      res.angle  = angle;
      res.sine   = to_result(s);
      res.cosine = to_result(c);
      return res;
   endfunction

   always @(posedge clock) begin
      angle_result want;
      logic [31:0] got_sine;
      logic [31:0] got_cosine;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            pending_sincos.push_back(sine_cosine_of(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            got_sine   = rsp_tdata[31:0];
            got_cosine = rsp_tdata[63:32];
            if (pending_sincos.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected result transfer: sine %h cosine %h",
                           got_sine, got_cosine);
               end
            end else begin
               want = pending_sincos.pop_front();
               compared_count++;
               if (got_sine !== want.sine || got_cosine !== want.cosine) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch for angle %h: sine exp %h got %h, cosine exp %h got %h",
                              want.angle, want.sine, got_sine, want.cosine, got_cosine);
                  end
               end
            end
         end
      end
      pending_count <= pending_sincos.size();
   end

endmodule

### test/tb_sine_cosine_minimax_top.sv
// ----------------------------------------------------------------------------
// tb_sine_cosine_minimax_top
// Drives angles into sine_cosine_minimax_top: range extremes, quadrant and
// half-turn boundaries, then random angles over the full range, small ranges
// and near multiples of pi/2, under three mixes of sender and receiver
// stalls. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_sine_cosine_minimax_top;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 550;
   localparam int HALF_PI_Q24  = 26353589;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;

   int mismatch_count;
   int pending_count;
   int compared_count;
   int tx_idle_pct = 27;
   int rx_idle_pct = 67;
   int cycle_count = 0;
   int angles_sent = 0;

   logic [31:0] directed_angles [$] = '{
      32'h00000000, 32'h00000001, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
      32'h80000001, 32'h55555555, 32'hAAAAAAAA, 32'd16777216, -32'sd16777216,
      32'd26353589, 32'd26353590, -32'sd26353589, -32'sd26353590,
      32'd52707179, -32'sd52707179, 32'd105414358, -32'sd105414358,
      32'd158121536, 32'd158121537, -32'sd158121536, -32'sd158121537
   };

   sine_cosine_minimax_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sine_cosine_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .compared_count (compared_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout: %0d results still owed", pending_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [31:0] random_angle();
      int k;
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(32'h1FFFFFFF) - 32'h10000000;
         2: begin
            k = int'($urandom_range(150)) - 75;
            return 32'(k * HALF_PI_Q24 + int'($urandom_range(128)) - 64);
         end
         default: begin
            k = int'($urandom >> $urandom_range(31));
            return $urandom_range(1) ? 32'(-k) : 32'(k);
         end
      endcase
   endfunction

   task automatic send_angle(input logic [31:0] angle);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= angle;
      do @(posedge clock); while (!req_tready);
      angles_sent++;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_angles[i]) begin
         send_angle(directed_angles[i]);
      end
      // hold off until the pipeline has drained
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            tx_idle_pct = 67;
            rx_idle_pct = 27;
         end else if (n == 2 * RANDOM_ITEMS / 3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         send_angle(random_angle());
      end
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (30) @(posedge clock);
      $display("Sent %0d angles: range extremes, quadrant and half-turn edges, random spread",
               angles_sent);
      $display("Compared %0d sine/cosine pairs under three stall mixes, %0d mismatches",
               compared_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
